>>> rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types, codes and helpers of the glob wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

   localparam int GWM_PATTERN_MAX = 64;

   localparam logic [7:0] STAR_CODE  = 8'h2A;
   localparam logic [7:0] QMARK_CODE = 8'h3F;

   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_SUBJECT = 1'b1;

   localparam logic [2:0] CSR_CASE_FOLD_ADDR = 3'd0;
   localparam logic       CASE_FOLD_RESET    = 1'b1;

   // handed from one cell to the next
   typedef struct packed {
      logic en;       // sender position lies inside the stored pattern
      logic m;        // sender matched the character and moves on
      logic skip;     // sender is an active star, receiver active by closure
      logic st_head;  // receiver is position zero of the start set
      logic st_skip;  // start set reaches receiver across a leading star
   } gwm_link_type;

   // common to all cells
   typedef struct packed {
      logic [7:0] wr_char;
      logic [7:0] sub_char;   // already folded
      logic       case_fold;
      logic       start;      // active set is the start set
      logic       upd;        // take the advanced set
      logic       has_char;
   } gwm_bcast_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic cf);
      logic [7:0] r;
      r = c;
      if (cf && (c inside {[8'h41:8'h5A]})) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: holds its pattern byte and active bit, and advances
// the active bit from its own byte and its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  gwm_pkg::gwm_bcast_type bcast,
   input  gwm_pkg::gwm_link_type  link_in,
   output gwm_pkg::gwm_link_type  link_out,
   input  wire                   en,
   input  wire                   wr_sel,
   output logic                  hit
);
   import gwm_pkg::*;

   logic [7:0] char_ff;
   logic       active_ff;
   logic       active_in;

   logic is_star;
   logic is_qmark;
   logic lit_hit;
   logic st_val;
   logic act_eff;
   logic pre;
   logic nxt;

   always_comb begin
      is_star  = (char_ff == STAR_CODE);
      is_qmark = (char_ff == QMARK_CODE);
      lit_hit  = (fold_char(char_ff, bcast.case_fold) == bcast.sub_char);
      st_val   = link_in.st_head | link_in.st_skip;
      act_eff  = bcast.start ? st_val : active_ff;
      // a star keeps its own bit, anything else moves right on a match
      pre      = (act_eff & en & is_star) | link_in.m;
      nxt      = pre | link_in.skip;

      link_out.en      = en;
      link_out.m       = act_eff & en & ~is_star & (is_qmark | lit_hit);
      link_out.skip    = pre & en & is_star;
      link_out.st_head = 1'b0;
      link_out.st_skip = link_in.st_head & en & is_star;

      // this position is the pattern end when the left one is inside and it is not
      hit = (bcast.has_char ? nxt : act_eff) & link_in.en & ~en;

      active_in = bcast.upd ? nxt : active_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         char_ff <= bcast.wr_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Matches subject strings against a stored glob pattern ('*' and '?').
// ----------------------------------------------------------------------------
// Usage:
//  req channel: tuser selects the kind (0 pattern character, 1 subject
//  character), tdata carries the byte and a has-character flag, tlast marks
//  the final item of a pattern or of a subject. A pattern is loaded once and
//  kept; any number of subjects may follow it.
//  rsp channel: one response per subject, carrying matched and the pattern
//  overflow flag, valid in the cycle after the subject's last item is accepted.
//  Throughput is one item per cycle while req_tready is high: a row of
//  PATTERN_MAX cells updates all active pattern positions in the cycle of the
//  item, and the pattern byte of a position lives in its cell. Runs of stars
//  are stored as one star so the closure over stars reaches only one neighbor.
//  csr port: register 0 (byte address 0) is case_fold, reset 1.
//  Reset clears the stored length and the overflow flag and selects the start
//  set; the first pattern item after a finished pattern starts a new one.
//  When the receiver stalls, the finished result waits in the output register
//  and req_tready stays high unless that register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_matcher #(
   parameter int PATTERN_MAX = gwm_pkg::GWM_PATTERN_MAX
) (
   input  wire         clock,
   input  wire         reset,
   // req_tdata: [7:0] char_code, [8] has_char, [15:9] zero
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,
   // req_tuser: [0] op
   input  wire         req_tuser,
   input  wire         req_tlast,
   // rsp_tdata: [0] matched, [1] pattern_overflow, [7:2] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import gwm_pkg::*;

   localparam int LW = $clog2(PATTERN_MAX + 1);

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] raw_ff, raw_in;
   logic          star_ff, star_in;
   logic          done_ff, done_in;
   logic          ovf_ff, ovf_in;
   logic          start_ff, start_in;
   logic          case_fold_ff, case_fold_in;
   logic          end_act_ff, end_act_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_data_ff, rsp_data_in;

   logic [7:0]    char_code;
   logic          has_char;
   logic          req_acc;
   logic          is_pat;
   logic          is_star;
   logic [LW-1:0] len_base;
   logic [LW-1:0] raw_base;
   logic          star_base;
   logic          wr_en;
   logic          upd;
   logic          result;
   logic          csr_wr;

   gwm_bcast_type           bcast;
   gwm_link_type            link [0:PATTERN_MAX];
   logic [PATTERN_MAX-1:0]  en_vec;
   logic [PATTERN_MAX-1:0]  wr_sel;
   logic [PATTERN_MAX:0]    hit_vec;

   logic end_st;
   logic end_eff;
   logic end_nxt;

   assign char_code  = req_tdata[7:0];
   assign has_char   = req_tdata[8];
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_acc    = req_tvalid & req_tready;
   assign is_pat     = (req_tuser == OP_PATTERN);
   assign is_star    = (char_code == STAR_CODE);

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & (csr_paddr == CSR_CASE_FOLD_ADDR);
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_CASE_FOLD_ADDR) begin
         csr_prdata = {31'd0, case_fold_ff};
      end
   end
   assign case_fold_in = csr_wr ? csr_pwdata[0] : case_fold_ff;

   // a new pattern starts from empty once the previous one is finished
   assign len_base  = done_ff ? '0 : len_ff;
   assign raw_base  = done_ff ? '0 : raw_ff;
   assign star_base = done_ff ? 1'b0 : star_ff;

   always_comb begin
      len_in   = len_ff;
      raw_in   = raw_ff;
      star_in  = star_ff;
      done_in  = done_ff;
      ovf_in   = ovf_ff;
      start_in = start_ff;
      wr_en    = 1'b0;
      upd      = 1'b0;
      result   = 1'b0;
      if (req_acc) begin
         if (is_pat) begin
            len_in   = len_base;
            raw_in   = raw_base;
            star_in  = star_base;
            ovf_in   = done_ff ? 1'b0 : ovf_ff;
            done_in  = req_tlast;
            start_in = 1'b1;
            if (has_char) begin
               if (raw_base < LW'(PATTERN_MAX)) begin
                  raw_in = LW'(raw_base + 1'b1);
                  // a star right after a stored star adds nothing
                  if (!(is_star && star_base)) begin
                     wr_en   = 1'b1;
                     len_in  = LW'(len_base + 1'b1);
                     star_in = is_star;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end else begin
            done_in = 1'b1;
            if (req_tlast) begin
               result   = 1'b1;
               start_in = 1'b1;
            end else if (has_char) begin
               upd      = 1'b1;
               start_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      bcast.wr_char   = char_code;
      bcast.sub_char  = fold_char(char_code, case_fold_ff);
      bcast.case_fold = case_fold_ff;
      bcast.start     = start_ff;
      bcast.upd       = upd;
      bcast.has_char  = has_char;
   end

   assign link[0] = '{en: 1'b1, m: 1'b0, skip: 1'b0, st_head: 1'b1, st_skip: 1'b0};

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      assign en_vec[i] = (LW'(i) < len_ff);
      assign wr_sel[i] = wr_en & (len_base == LW'(i));

      gwm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bcast    (bcast),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .en       (en_vec[i]),
         .wr_sel   (wr_sel[i]),
         .hit      (hit_vec[i])
      );
   end

   // the position after the last cell holds no character
   always_comb begin
      end_st  = link[PATTERN_MAX].st_head | link[PATTERN_MAX].st_skip;
      end_eff = start_ff ? end_st : end_act_ff;
      end_nxt = link[PATTERN_MAX].m | link[PATTERN_MAX].skip;
      end_act_in = upd ? end_nxt : end_act_ff;
   end

   assign hit_vec[PATTERN_MAX] = (has_char ? end_nxt : end_eff) & link[PATTERN_MAX].en;

   assign rsp_valid_in = result | (rsp_valid_ff & ~rsp_tready);
   assign rsp_data_in  = result ? {ovf_ff, |hit_vec} : rsp_data_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         raw_ff       <= '0;
         star_ff      <= 1'b0;
         done_ff      <= 1'b1;
         ovf_ff       <= 1'b0;
         start_ff     <= 1'b1;
         case_fold_ff <= CASE_FOLD_RESET;
         end_act_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         raw_ff       <= raw_in;
         star_ff      <= star_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         start_ff     <= start_in;
         case_fold_ff <= case_fold_in;
         end_act_ff   <= end_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/gwm_checker.sv
// ----------------------------------------------------------------------------
// gwm_checker
// Port-level checks of the glob wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        req_tuser,
   input wire        req_tlast,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata
);
   import gwm_pkg::*;

   logic sub_end;
   assign sub_end = req_tvalid & req_tready & (req_tuser == OP_SUBJECT) & req_tlast;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_ready_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a waiting response");

   a_subject_end_reports: assert property (@(posedge clock) disable iff (reset)
      sub_end |=> rsp_tvalid)
      else $error("no response after end of subject");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !sub_end && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response without end of subject");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

`default_nettype wire

>>> tb/tb_glob_wildcard_matcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glob_wildcard_matcher
// Self-checking bench for the glob wildcard matcher.
// ----------------------------------------------------------------------------
// Patterns and subjects are streamed into the request channel. Every accepted
// item also steps a behavioral copy of the matcher kept in this bench, which
// queues the verdict that a subject's last item should produce. Each response
// is checked against the oldest queued verdict. Both channels idle at random,
// and the case-fold register is rewritten between phases while idle.
// ----------------------------------------------------------------------------

module tb_glob_wildcard_matcher;
   import gwm_pkg::*;

   localparam int PMAX        = GWM_PATTERN_MAX;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 4;
   localparam int ITEMS_TOTAL = 800;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b1;
   wire  [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   // behavioral copy of the matcher
   logic [7:0]  pat_mem [PMAX];
   int          pat_len = 0;
   logic [PMAX:0] act_pos = (PMAX+1)'(1);
   logic        pat_done = 1'b1;
   logic        ovf_flag = 1'b0;
   logic        fold_en = CASE_FOLD_RESET;

   verdict_type verdicts_due [$];
   verdict_type want;
   int          mismatches = 0;
   int          items_sent = 0;
   int          cycles = 0;
   int          stall_left = 0;
   bit          no_gaps = 1'b0;

   glob_wildcard_matcher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d results outstanding", $time,
                  verdicts_due.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // a star may match nothing, so activity flows across it
   function automatic logic [PMAX:0] star_closure(input logic [PMAX:0] s);
      logic [PMAX:0] r;
      r = s;
      for (int i = 0; i < pat_len; i++) begin
         if (r[i] && pat_mem[i] == STAR_CODE) begin
            r[i+1] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic void enter_start_set();
      act_pos = '0;
      act_pos[0] = 1'b1;
      act_pos = star_closure(act_pos);
   endfunction

   function automatic void step_glob(input logic op, input logic [7:0] ch,
                                     input logic has, input logic lst);
      logic [PMAX:0] nxt;
      logic [7:0]    fc;
      verdict_type   v;
      if (op == OP_PATTERN) begin
         if (pat_done) begin
            pat_done = 1'b0;
            pat_len  = 0;
            ovf_flag = 1'b0;
         end
         if (has) begin
            if (pat_len < PMAX) begin
               pat_mem[pat_len] = ch;
               pat_len++;
            end else begin
               ovf_flag = 1'b1;
            end
         end
         if (lst) begin
            pat_done = 1'b1;
            enter_start_set();
         end
         return;
      end
      // a subject implicitly closes an unfinished pattern
      if (!pat_done) begin
         pat_done = 1'b1;
         enter_start_set();
      end
      if (has) begin
         nxt = '0;
         fc  = lower_ascii(ch);
         for (int i = 0; i < pat_len; i++) begin
            if (act_pos[i]) begin
               if (pat_mem[i] == STAR_CODE) begin
                  nxt[i] = 1'b1;
               end else if (pat_mem[i] == QMARK_CODE || lower_ascii(pat_mem[i]) == fc) begin
                  nxt[i+1] = 1'b1;
               end
            end
         end
         act_pos = star_closure(nxt);
      end
      if (lst) begin
         v.matched  = act_pos[pat_len];
         v.overflow = ovf_flag;
         verdicts_due.insert(verdicts_due.size(), v);
         enter_start_set();
      end
   endfunction

   function automatic int burst_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      if (no_gaps || $urandom_range(0, 99) < 55) return 0;
      return burst_len();
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
      return base + 8'($urandom_range(0, 2));
   endfunction

   function automatic logic [7:0] swap_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
      if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] rand_pattern_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return STAR_CODE;
      if (r < 35) return QMARK_CODE;
      if (r < 85) return rand_letter();
      return 8'($urandom_range(0, 255));
   endfunction

   // response ready with random stall bursts
   always @(posedge clock) begin
      if (stall_left == 0 && !no_gaps && $urandom_range(0, 99) < 20) begin
         stall_left = burst_len();
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual matched=%0b overflow=%0b",
                     $time, rsp_tdata[0], rsp_tdata[1]);
            mismatches++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tdata[0] !== want.matched) begin
               $display("%0t: matched: expected %0b, actual %0b", $time, want.matched,
                        rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[1] !== want.overflow) begin
               $display("%0t: pattern_overflow: expected %0b, actual %0b", $time,
                        want.overflow, rsp_tdata[1]);
               mismatches++;
            end
         end
      end
   end

   task automatic send_item(input logic op, input logic [7:0] ch, input logic has,
                            input logic lst);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, has, ch};
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_glob(op, ch, has, lst);
      items_sent++;
   endtask

   // hold off until every verdict is back and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == CSR_CASE_FOLD_ADDR) begin
         fold_en = data[0];
      end
   endtask

   // one pattern followed by a few subjects, mostly built to match it
   task automatic run_session(input int forced_len);
      logic [7:0] pat [$];
      logic [7:0] subj [$];
      int n, used, k, close_mode, idx;
      bit trail;
      if (forced_len >= 0) begin
         n = forced_len;
      end else begin
         n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 20);
      end
      for (int i = 0; i < n; i++) begin
         pat.insert(pat.size(), rand_pattern_char());
      end
      close_mode = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            send_item(OP_PATTERN, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_item(OP_PATTERN, pat[i], 1'b1, close_mode < 7 && i == n - 1);
      end
      // close on an empty item, or leave it for the subject to close
      if ((close_mode >= 7 && close_mode <= 8) || (close_mode < 7 && n == 0)) begin
         send_item(OP_PATTERN, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      used = (n < PMAX) ? n : PMAX;
      // long patterns get a single subject
      k = (n > 20) ? 1 : $urandom_range(1, 4);
      for (int s = 0; s < k; s++) begin
         subj.delete();
         for (int i = 0; i < used; i++) begin
            if (pat[i] == STAR_CODE) begin
               repeat ($urandom_range(0, 3)) subj.insert(subj.size(), rand_letter());
            end else if (pat[i] == QMARK_CODE) begin
               subj.insert(subj.size(),
                           $urandom_range(0, 3) ? rand_letter() : 8'($urandom_range(0, 255)));
            end else begin
               subj.insert(subj.size(), $urandom_range(0, 2) ? pat[i] : swap_case(pat[i]));
            end
         end
         if ($urandom_range(0, 99) < 35) begin
            case ($urandom_range(0, 2))
               0: begin
                  if (subj.size() > 0) begin
                     idx = $urandom_range(0, subj.size() - 1);
                     subj[idx] = rand_letter();
                  end
               end
               1: begin
                  if (subj.size() > 0) begin
                     idx = $urandom_range(0, subj.size() - 1);
                     subj.delete(idx);
                  end
               end
               default: begin
                  subj.insert(subj.size(), rand_letter());
               end
            endcase
         end
         if ($urandom_range(0, 19) == 0) begin
            send_item(OP_SUBJECT, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end
         trail = ($urandom_range(0, 99) < 15);
         if (subj.size() == 0) begin
            send_item(OP_SUBJECT, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end else begin
            for (int j = 0; j < subj.size(); j++) begin
               if ($urandom_range(0, 29) == 0) begin
                  send_item(OP_SUBJECT, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
               end
               send_item(OP_SUBJECT, subj[j], 1'b1, !trail && j == subj.size() - 1);
            end
            if (trail) begin
               send_item(OP_SUBJECT, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
         end
      end
   endtask

   task automatic test_directed();
      // empty subject against the empty pattern left by reset
      send_item(OP_SUBJECT, 8'h00, 1'b0, 1'b1);
      // lone star matches the empty subject
      send_item(OP_PATTERN, STAR_CODE, 1'b1, 1'b1);
      send_item(OP_SUBJECT, 8'h00, 1'b0, 1'b1);
      // folded literal plus a single-character wildcard
      send_item(OP_PATTERN, 8'h41, 1'b1, 1'b0);
      send_item(OP_PATTERN, QMARK_CODE, 1'b1, 1'b1);
      send_item(OP_SUBJECT, 8'h61, 1'b1, 1'b0);
      send_item(OP_SUBJECT, 8'h62, 1'b1, 1'b1);
      send_item(OP_SUBJECT, 8'h61, 1'b1, 1'b0);
      send_item(OP_SUBJECT, 8'hFF, 1'b0, 1'b1);
      // empty pattern closed by an item without a character, zero byte subject
      send_item(OP_PATTERN, 8'hFF, 1'b0, 1'b1);
      send_item(OP_SUBJECT, 8'h00, 1'b1, 1'b1);
      // unterminated pattern closed by the subject
      send_item(OP_PATTERN, 8'h00, 1'b1, 1'b0);
      send_item(OP_PATTERN, 8'hFF, 1'b1, 1'b0);
      send_item(OP_PATTERN, STAR_CODE, 1'b1, 1'b0);
      send_item(OP_SUBJECT, 8'h00, 1'b1, 1'b0);
      send_item(OP_SUBJECT, 8'hFF, 1'b1, 1'b0);
      send_item(OP_SUBJECT, 8'h5A, 1'b1, 1'b1);
      // exact compare
      drain();
      csr_write(CSR_CASE_FOLD_ADDR, 32'd0);
      send_item(OP_PATTERN, 8'h61, 1'b1, 1'b1);
      send_item(OP_SUBJECT, 8'h41, 1'b1, 1'b1);
      send_item(OP_SUBJECT, 8'h61, 1'b1, 1'b1);
      drain();
      csr_write(CSR_CASE_FOLD_ADDR, 32'd1);
   endtask

   task automatic test_pattern_overflow();
      run_session(PMAX);
      run_session(PMAX + 1);
      drain();
      csr_write(CSR_CASE_FOLD_ADDR, 32'd0);
      run_session(PMAX + 7);
      // a short pattern after a truncated one starts clean
      run_session(3);
      drain();
      csr_write(CSR_CASE_FOLD_ADDR, 32'd1);
   endtask

   task automatic test_back_to_back();
      no_gaps = 1'b1;
      repeat (6) run_session(-1);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_sessions();
      logic fold_pick;
      while (items_sent < ITEMS_TOTAL) begin
         if ($urandom_range(0, 9) == 0) begin
            drain();
            fold_pick = 1'($urandom_range(0, 1));
            csr_write(CSR_CASE_FOLD_ADDR, {31'b0, fold_pick});
         end else if ($urandom_range(0, 19) == 0) begin
            drain();
         end
         no_gaps = ($urandom_range(0, 4) == 0);
         run_session(-1);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pattern_overflow();
      test_back_to_back();
      test_random_sessions();
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> glob_wildcard_matcher.f
rtl/gwm_pkg.sv
rtl/gwm_cell.sv
rtl/glob_wildcard_matcher.sv
rtl/gwm_checker.sv
tb/tb_glob_wildcard_matcher.sv
